// ===== rtl/core/sfw_pkg.sv =====
// ----------------------------------------------------------------------------
// sfw_pkg
// Shared constants for the square-free word checker.
// ----------------------------------------------------------------------------
package sfw_pkg;

  // Parameter defaults
  localparam int MAX_SYMBOLS_DEF  = 16;
  localparam int SYMBOL_WIDTH_DEF = 3;

  // Fixed field widths of the request
  localparam int WORD_BITS_W = 48;
  localparam int WORD_LEN_W  = 5;

endpackage

// ===== rtl/core/square_free_word_check.sv =====
// ----------------------------------------------------------------------------
// square_free_word_check
// Decides whether a packed word holds no adjacent repeated factor (xx).
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   in_word_bits, in_word_length            start / busy
//  result    out_square_free                         out_valid (1-cycle strobe)
//
//  A request tests one half-length per cycle, 1 .. MAX_SYMBOLS/2
//  (8 at the defaults), on the single match unit that checks all start
//  positions of one half-length at once. A square ends the search early.
//  The result strobes on the cycle after the last test; busy is already low
//  then, so the next request may be taken in that cycle.
//  Reset clears the sequencer and the strobe. The receiver cannot stall.
// ----------------------------------------------------------------------------
module square_free_word_check
  import sfw_pkg::*;
#(
  parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
  parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [WORD_BITS_W-1:0] in_word_bits,
  input  logic [WORD_LEN_W-1:0]  in_word_length,
  output logic                   out_valid,
  output logic                   out_square_free
);

  localparam int WORD_W = MAX_SYMBOLS * SYMBOL_WIDTH;
  localparam int EXT_W  = (WORD_W > WORD_BITS_W) ? WORD_W : WORD_BITS_W;
  localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1);
  localparam int HALF_W = $clog2(MAX_SYMBOLS / 2 + 1);
  localparam int CW     = LEN_W + 2;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r,   state_nxt;
  logic [WORD_W-1:0] sym_r,     sym_nxt;
  logic [LEN_W-1:0]  len_r,     len_nxt;
  logic [HALF_W-1:0] half_r,    half_nxt;
  logic              valid_r,   valid_nxt;
  logic              sqfree_r,  sqfree_nxt;

  logic [EXT_W-1:0]  word_ext;
  logic              accept;
  logic              hit;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     two_half;
  logic [CW-1:0]     two_next;

  assign accept   = start && (state_r == ST_IDLE);
  assign word_ext = EXT_W'(in_word_bits);
  assign len_ext  = CW'(len_r);
  assign two_half = {CW'(half_r)} << 1;
  assign two_next = two_half + CW'(2);

  sfw_match_unit #(
    .MAX_SYMBOLS  (MAX_SYMBOLS),
    .SYMBOL_WIDTH (SYMBOL_WIDTH)
  ) u_match (
    .sym_i  (sym_r),
    .len_i  (len_r),
    .half_i (half_r),
    .hit_o  (hit)
  );

  always_comb begin
    state_nxt  = state_r;
    sym_nxt    = sym_r;
    len_nxt    = len_r;
    half_nxt   = half_r;
    valid_nxt  = 1'b0;
    sqfree_nxt = sqfree_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sym_nxt   = word_ext[WORD_W-1:0];
          len_nxt   = (in_word_length > WORD_LEN_W'(MAX_SYMBOLS)) ?
                      LEN_W'(MAX_SYMBOLS) : LEN_W'(in_word_length);
          half_nxt  = HALF_W'(1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (two_half > len_ext) begin
          // length 0 or 1
          sqfree_nxt = 1'b1;
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (hit || (two_next > len_ext)) begin
          sqfree_nxt = !hit;
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          half_nxt = half_r + HALF_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r    <= sym_nxt;
    len_r    <= len_nxt;
    half_r   <= half_nxt;
    sqfree_r <= sqfree_nxt;
  end

  assign busy            = (state_r == ST_RUN);
  assign out_valid       = valid_r;
  assign out_square_free = sqfree_r;

  // result strobe only ever leaves the sequencer idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer running");

  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN))
    else $error("accepted request did not start the search");

  a_half_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (CW'(half_r) <= CW'(MAX_SYMBOLS / 2)))
    else $error("half-length beyond word bound");

  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe on back-to-back cycles");

endmodule

// ===== rtl/core/sfw_match_unit.sv =====
// ----------------------------------------------------------------------------
// sfw_match_unit
// Tests one square half-length: compares every symbol with the one half
// positions later and looks for a run of half matches inside the word.
// ----------------------------------------------------------------------------
module sfw_match_unit
  import sfw_pkg::*;
#(
  parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
  parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF,
  localparam int WORD_W = MAX_SYMBOLS * SYMBOL_WIDTH,
  localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1),
  localparam int HALF_W = $clog2(MAX_SYMBOLS / 2 + 1)
) (
  input  logic [WORD_W-1:0] sym_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic [HALF_W-1:0] half_i,
  output logic              hit_o
);

  localparam int SH_W = $clog2(WORD_W + 1);
  localparam int CW   = LEN_W + 2;

  logic [SH_W-1:0]        shamt;
  logic [WORD_W-1:0]      shifted;
  logic [MAX_SYMBOLS-1:0] eq;
  logic [MAX_SYMBOLS-1:0] hmask;
  logic [MAX_SYMBOLS-1:0] win;
  logic [CW-1:0]          two_half;
  logic [CW-1:0]          len_ext;

  assign shamt    = SH_W'(half_i) * SH_W'(SYMBOL_WIDTH);
  assign shifted  = sym_i >> shamt;
  assign hmask    = (MAX_SYMBOLS'(1) << half_i) - MAX_SYMBOLS'(1);
  assign two_half = {CW'(half_i)} << 1;
  assign len_ext  = CW'(len_i);

  always_comb begin
    for (int p = 0; p < MAX_SYMBOLS; p++) begin
      eq[p] = (sym_i[p*SYMBOL_WIDTH +: SYMBOL_WIDTH] ==
               shifted[p*SYMBOL_WIDTH +: SYMBOL_WIDTH]);
    end
  end

  // a square at start s needs eq[s .. s+half-1] and s + 2*half <= len
  always_comb begin
    hit_o = 1'b0;
    win   = '0;
    for (int s = 0; s < MAX_SYMBOLS; s++) begin
      win = (eq >> s) | ~hmask;
      if (((CW'(s) + two_half) <= len_ext) && (&win)) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

// ===== bench/square_free_word_check_test.sv =====
// ----------------------------------------------------------------------------
// square_free_word_check_test
// Self-checking bench for the square-free word checker. A queue of requests
// (directed corner words, then random words built square-free and with
// planted squares, plus raw noise) feeds a clocked driver with random gaps.
// A clocked monitor compares every result strobe with a predicted verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module square_free_word_check_test;
  import sfw_pkg::*;

  localparam int SW          = SYMBOL_WIDTH_DEF;
  localparam int MS          = MAX_SYMBOLS_DEF;
  localparam int RAND_WORDS  = 1700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 20;

  typedef struct packed {
    logic [WORD_BITS_W-1:0] bits;
    logic [WORD_LEN_W-1:0]  len;
  } word_req_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [WORD_BITS_W-1:0] in_word_bits = '0;
  logic [WORD_LEN_W-1:0]  in_word_length = '0;
  logic                   out_valid;
  logic                   out_square_free;

  word_req_t word_pending_q[$];
  logic      verdict_q[$];

  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int free_seen = 0;
  int square_seen = 0;
  int saturated_sent = 0;
  int idle_left = 0;
  int mode_left = 0;
  bit bursty = 1'b0;

  square_free_word_check dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_word_bits   (in_word_bits),
    .in_word_length (in_word_length),
    .out_valid      (out_valid),
    .out_square_free(out_square_free)
  );

  always #5 clk = ~clk;

  // Verdict: direct comparison over every half-length and start position.
  function automatic logic square_free_of(input logic [WORD_BITS_W-1:0] bits,
                                          input logic [WORD_LEN_W-1:0] len_in);
    logic [SW-1:0] sym [MS];
    int n;
    bit same;
    logic verdict;
    n = (len_in > MS) ? MS : int'(len_in);
    for (int p = 0; p < MS; p++) sym[p] = bits[p*SW +: SW];
    verdict = 1'b1;
    for (int h = 1; 2*h <= n; h++) begin
      for (int s = 0; s + 2*h <= n; s++) begin
        same = 1'b1;
        for (int k = 0; k < h; k++) begin
          if (sym[s+k] != sym[s+h+k]) same = 1'b0;
        end
        if (same) verdict = 1'b0;
      end
    end
    return verdict;
  endfunction

  function automatic logic [WORD_BITS_W-1:0] rand_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[WORD_BITS_W-1:0];
  endfunction

  // Random greedy extension over a shuffled alphabet; stops short on a dead end.
  // Bits above the reached length keep random junk.
  function automatic word_req_t build_free_word(input int alpha, input int target);
    word_req_t w;
    logic [SW-1:0] map [8];
    logic [SW-1:0] tmp;
    int j, r, n;
    bit ok;
    for (int i = 0; i < 8; i++) map[i] = SW'(i);
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = map[i];
      map[i] = map[j];
      map[j] = tmp;
    end
    w.bits = rand_bits();
    n = 0;
    for (int pos = 0; pos < target; pos++) begin
      ok = 1'b0;
      r = $urandom_range(0, alpha - 1);
      for (int t = 0; t < alpha && !ok; t++) begin
        w.bits[pos*SW +: SW] = map[(r + t) % alpha];
        ok = square_free_of(w.bits, WORD_LEN_W'(pos + 1));
      end
      if (!ok) break;
      n = pos + 1;
    end
    w.len = WORD_LEN_W'(n);
    return w;
  endfunction

  // Copy the factor at s of length h right behind itself.
  function automatic word_req_t plant_square(input word_req_t w, input int h,
                                             input int s);
    word_req_t o;
    o = w;
    for (int k = 0; k < h; k++) o.bits[(s+h+k)*SW +: SW] = o.bits[(s+k)*SW +: SW];
    return o;
  endfunction

  function automatic word_req_t ternary_full_word();
    word_req_t w;
    w = build_free_word(3, MS);
    for (int a = 0; a < 500 && w.len < MS; a++) w = build_free_word(3, MS);
    return w;
  endfunction

  function automatic word_req_t random_word();
    word_req_t w;
    int pick, h, s;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w = build_free_word($urandom_range(3, 8),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, MS) : MS);
      if ($urandom_range(0, 9) == 0) w.len = WORD_LEN_W'($urandom_range(MS + 1, 31));
    end else if (pick < 75) begin
      w = build_free_word($urandom_range(3, 8), $urandom_range(2, MS));
      if (w.len >= 2) begin
        h = $urandom_range(1, w.len / 2);
        s = $urandom_range(0, w.len - 2*h);
        w = plant_square(w, h, s);
      end
    end else if (pick < 90) begin
      w.bits = rand_bits();
      w.len  = WORD_LEN_W'($urandom_range(0, 31));
    end else begin
      w.bits = rand_bits();
      w.len  = ($urandom_range(0, 1) == 0) ? WORD_LEN_W'($urandom_range(0, 3))
                                           : WORD_LEN_W'($urandom_range(MS + 1, 31));
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    if (bursty) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  // Request driver
  always @(posedge clk) begin
    word_req_t nxt;
    bit taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        verdict_q.push_back(square_free_of(in_word_bits, in_word_length));
        words_sent++;
        if (in_word_length > MS) saturated_sent++;
        if (mode_left == 0) begin
          bursty = ($urandom_range(0, 2) == 0);
          mode_left = $urandom_range(50, 150);
        end else begin
          mode_left--;
        end
        idle_left = pick_gap();
      end
      if (start && !taken) begin
        // request held until the block takes it
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (word_pending_q.size() > 0) begin
        nxt = word_pending_q.pop_front();
        start          <= 1'b1;
        in_word_bits   <= nxt.bits;
        in_word_length <= nxt.len;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result square_free=%0b", out_square_free));
      end else begin
        want = verdict_q.pop_front();
        if (out_square_free !== want)
          report_mismatch($sformatf("square_free got %0b want %0b", out_square_free, want));
        if (want) free_seen++;
        else square_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    word_req_t w, tern;
    tern = ternary_full_word();
    word_pending_q.push_back('{'0, 5'd0});
    word_pending_q.push_back('{'1, 5'd0});
    word_pending_q.push_back('{'1, 5'd1});
    word_pending_q.push_back('{48'h0, 5'd2});           // 00
    word_pending_q.push_back('{48'h8, 5'd2});           // 01
    word_pending_q.push_back('{48'h08, 5'd3});          // 010
    word_pending_q.push_back('{48'hE38, 5'd4});         // 0707: abab
    word_pending_q.push_back('{'0, 5'd16});
    word_pending_q.push_back('{'1, 5'd16});
    word_pending_q.push_back('{'0, 5'd31});             // length saturates
    word_pending_q.push_back('{'1, 5'd17});
    word_pending_q.push_back(tern);
    word_pending_q.push_back('{tern.bits, 5'd17});
    word_pending_q.push_back('{tern.bits, 5'd31});
    word_pending_q.push_back(plant_square(tern, 1, MS - 2));   // square at the end
    word_pending_q.push_back(plant_square(tern, 1, 0));        // square at the front
    w = plant_square(tern, MS / 2, 0);                         // whole word is xx
    word_pending_q.push_back(w);
    word_pending_q.push_back('{w.bits, 5'(MS - 1)});
    w = build_free_word(8, 5);
    for (int p = 0; p < MS; p++)                               // junk above length
      if (p >= w.len) w.bits[p*SW +: SW] = '1;
    word_pending_q.push_back(w);
    for (int p = 0; p < MS; p++)
      if (p >= w.len) w.bits[p*SW +: SW] = '0;
    word_pending_q.push_back(w);
    for (int i = 0; i < RAND_WORDS; i++) word_pending_q.push_back(random_word());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (word_pending_q.size() > 0 || verdict_q.size() > 0 || start) @(negedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("checked %0d words (%0d square-free, %0d with a square, %0d long lengths)",
             words_sent, free_seen, square_seen, saturated_sent);
    $display("%0d mismatches in %0d cycles", errors, cycles);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
